// ===== hdl/ffa_pkg.sv =====
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int GRANULES     = 65536;
  localparam int GRAN_W       = 16;
  localparam int SIZE_W       = GRAN_W + 1;
  localparam int SUM_W        = SIZE_W + 2;
  localparam int GRAN_SHIFT   = 4;
  localparam int HEADER_BYTES = 32;
  localparam int FOOTER_BYTES = 16;
  localparam int SPLIT_SLACK  = 32;
  localparam int REQ_W        = 21;
  localparam int NEED_W       = REQ_W + 1 - GRAN_SHIFT;
  localparam int ADDR_W       = 32;
  localparam int CNT_W        = 48;
  localparam int PADDR_W      = 3;
  localparam int SPLIT_GRAN   = (HEADER_BYTES + FOOTER_BYTES + SPLIT_SLACK) / 16;

  localparam logic [SIZE_W-1:0] NIL = SIZE_W'(GRANULES);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_ZERO    = 2'd1,
    STAT_NOFIT   = 2'd2,
    STAT_IGNORED = 2'd3
  } stat_t;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } tag_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE,
    ST_A_READ, ST_A_EVAL, ST_A_S1, ST_A_S2, ST_A_S3, ST_A_U1,
    ST_F_READ, ST_F_CHK, ST_F_NREAD, ST_F_NCHK, ST_F_PREAD, ST_F_PCHK0,
    ST_F_PCHK1, ST_F_PUSH1, ST_F_PUSH2, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LATCH, OP_DECODE,
    OP_A_READ, OP_A_NEXT, OP_A_TAKE, OP_A_S1, OP_A_S2, OP_A_S3, OP_A_U1,
    OP_F_READ, OP_F_CHK, OP_F_NREAD, OP_F_NMERGE, OP_F_PREAD1, OP_F_PMERGE,
    OP_F_PUSH1, OP_F_PUSH2
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic req_zero;
    logic free_bad;
    logic walk_end;
    logic fit;
    logic split;
    logic free_ok;
    logic nx_valid;
    logic nmerge;
    logic g_nonzero;
    logic prev_cand;
    logic pmerge;
    logic clear_last;
  } dp_stat_t;

endpackage

// ===== hdl/ffa_dp.sv =====
`timescale 1ns / 1ps
module ffa_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ffa_pkg::dp_cmd_t              ctl,
  output ffa_pkg::dp_stat_t             st,
  input  logic [ffa_pkg::ADDR_W-1:0]    heap_base,
  input  logic                          cmd,
  input  logic [ffa_pkg::REQ_W-1:0]     request_bytes,
  input  logic [ffa_pkg::ADDR_W-1:0]    block_address,
  output logic [ffa_pkg::ADDR_W-1:0]    result_address,
  output logic [1:0]                    status,
  output logic [ffa_pkg::CNT_W-1:0]     used_bytes,
  output logic [ffa_pkg::CNT_W-1:0]     allocated_bytes,
  output logic                          merged_forward,
  output logic                          merged_backward
);

  localparam int GW = ffa_pkg::GRAN_W;
  localparam int SW = ffa_pkg::SIZE_W;
  localparam int UW = ffa_pkg::SUM_W;
  localparam int NW = ffa_pkg::NEED_W;
  localparam int AW = ffa_pkg::ADDR_W;
  localparam int CW = ffa_pkg::CNT_W;
  localparam int RW = ffa_pkg::REQ_W;
  localparam int GS = ffa_pkg::GRAN_SHIFT;

  ffa_pkg::tag_t   head_mem [ffa_pkg::GRANULES];
  ffa_pkg::tag_t   tail_mem [ffa_pkg::GRANULES];
  logic [SW-1:0]   prev_mem [ffa_pkg::GRANULES];
  logic [SW-1:0]   next_mem [ffa_pkg::GRANULES];

  ffa_pkg::tag_t   rd_head, rd_tail;
  logic [SW-1:0]   rd_prev, rd_next;

  logic            in_cmd;
  logic [RW-1:0]   in_req;
  logic [AW-1:0]   in_addr;
  logic            started;
  logic [SW-1:0]   list_head;
  logic [CW-1:0]   given, returned;
  logic [NW-1:0]   need;
  logic [SW-1:0]   cur, steps, sz, p_lk, n_lk;
  logic [GW-1:0]   g, pg, clr_idx;
  logic [AW-1:0]   res_addr;
  ffa_pkg::stat_t  stat;
  logic            mf, mb;

  logic [SW-1:0]   hs, san_prev, san_next, nx, sum_sz, ul_p, ul_n;
  logic [RW:0]     need_sum;
  logic [NW-1:0]   need_c;
  logic [AW:0]     lo, off;
  logic [GW-1:0]   g_c, nb, pg_c, rd_addr;

  logic            tw_en, tw_free;
  logic [GW-1:0]   tw_g;
  logic [SW-1:0]   tw_sz;
  logic            head_we, tail_we, prev_we, next_we;
  logic [GW-1:0]   head_wa, tail_wa, prev_wa, next_wa;
  ffa_pkg::tag_t   head_wd, tail_wd;
  logic [SW-1:0]   prev_wd, next_wd;

  assign hs       = rd_head.size;
  assign san_prev = rd_prev[SW-1] ? ffa_pkg::NIL : rd_prev;
  assign san_next = rd_next[SW-1] ? ffa_pkg::NIL : rd_next;
  assign need_sum = {1'b0, in_req} + (RW+1)'(ffa_pkg::HEADER_BYTES + ffa_pkg::FOOTER_BYTES + 15);
  assign need_c   = need_sum[RW:GS];
  assign lo       = {1'b0, heap_base} + (AW+1)'(ffa_pkg::HEADER_BYTES);
  assign off      = {1'b0, in_addr} - lo;
  assign g_c      = off[GW+GS-1:GS];
  assign nb       = cur[GW-1:0] + need[GW-1:0];
  assign nx       = {1'b0, g} + sz;
  assign sum_sz   = sz + hs;
  assign pg_c     = g - rd_tail.size[GW-1:0];

  // Status toward the controller.
  always_comb begin
    st.is_free    = (in_cmd == ffa_pkg::CMD_FREE);
    st.req_zero   = (in_req == '0);
    st.free_bad   = (in_addr == '0) || !started || ({1'b0, in_addr} < lo) ||
                    (off[AW:GW+GS] != '0) || (off[GS-1:0] != '0);
    st.walk_end   = cur[SW-1] || steps[SW-1];
    st.fit        = rd_head.free && (hs != '0) &&
                    (UW'(cur[GW-1:0]) + UW'(hs) <= UW'(ffa_pkg::GRANULES)) &&
                    (UW'(hs) >= UW'(need));
    st.split      = (UW'(hs) - UW'(need)) > UW'(ffa_pkg::SPLIT_GRAN);
    st.free_ok    = (hs != '0) && (UW'(g) + UW'(hs) <= UW'(ffa_pkg::GRANULES));
    st.nx_valid   = !nx[SW-1];
    st.nmerge     = rd_head.free && (hs != '0) &&
                    (UW'(g) + UW'(sz) + UW'(hs) <= UW'(ffa_pkg::GRANULES));
    st.g_nonzero  = (g != '0);
    st.prev_cand  = (rd_tail.size != '0) && (rd_tail.size <= SW'(g));
    st.pmerge     = rd_head.free && (hs != '0) &&
                    (UW'(pg) + UW'(sz) + UW'(hs) <= UW'(ffa_pkg::GRANULES));
    st.clear_last = (clr_idx == GW'(ffa_pkg::GRANULES - 1));
  end

  always_comb begin
    unique case (ctl.op)
      ffa_pkg::OP_F_READ:   rd_addr = g;
      ffa_pkg::OP_F_NREAD:  rd_addr = nx[GW-1:0];
      ffa_pkg::OP_F_PREAD1: rd_addr = pg_c;
      default:              rd_addr = cur[GW-1:0];
    endcase
  end

  // Tag and link write ports.
  always_comb begin
    tw_en   = 1'b0;
    tw_g    = cur[GW-1:0];
    tw_sz   = sz;
    tw_free = 1'b1;
    ul_p    = san_prev;
    ul_n    = san_next;
    prev_we = 1'b0;
    prev_wa = cur[GW-1:0];
    prev_wd = ffa_pkg::NIL;
    next_we = 1'b0;
    next_wa = cur[GW-1:0];
    next_wd = ffa_pkg::NIL;
    if (ctl.op == ffa_pkg::OP_A_U1) begin
      ul_p = p_lk;
      ul_n = n_lk;
    end
    unique case (ctl.op)
      ffa_pkg::OP_A_S1: begin
        tw_en   = 1'b1;
        tw_g    = nb;
        tw_sz   = sz - need[SW-1:0];
        prev_we = 1'b1;
        prev_wa = nb;
        prev_wd = p_lk;
        next_we = 1'b1;
        next_wa = nb;
        next_wd = n_lk;
      end
      ffa_pkg::OP_A_S2: begin
        prev_we = !n_lk[SW-1];
        prev_wa = n_lk[GW-1:0];
        prev_wd = SW'(nb);
        next_we = !p_lk[SW-1];
        next_wa = p_lk[GW-1:0];
        next_wd = SW'(nb);
      end
      ffa_pkg::OP_A_S3: begin
        tw_en   = 1'b1;
        tw_sz   = need[SW-1:0];
        tw_free = 1'b0;
        prev_we = 1'b1;
        next_we = 1'b1;
      end
      ffa_pkg::OP_A_U1, ffa_pkg::OP_F_NMERGE, ffa_pkg::OP_F_PMERGE: begin
        tw_en   = 1'b1;
        if (ctl.op == ffa_pkg::OP_A_U1) begin
          tw_free = 1'b0;
        end else begin
          tw_sz = sum_sz;
          tw_g  = (ctl.op == ffa_pkg::OP_F_PMERGE) ? pg : g;
        end
        next_we = !ul_p[SW-1];
        next_wa = ul_p[GW-1:0];
        next_wd = ul_n;
        prev_we = !ul_n[SW-1];
        prev_wa = ul_n[GW-1:0];
        prev_wd = ul_p;
      end
      ffa_pkg::OP_F_CHK: begin
        tw_en = 1'b1;
        tw_g  = g;
        tw_sz = hs;
      end
      ffa_pkg::OP_F_PUSH1: begin
        prev_we = 1'b1;
        prev_wa = g;
        next_we = 1'b1;
        next_wa = g;
        next_wd = list_head;
      end
      ffa_pkg::OP_F_PUSH2: begin
        prev_we = !list_head[SW-1];
        prev_wa = list_head[GW-1:0];
        prev_wd = SW'(g);
      end
      default: begin
      end
    endcase

    head_we = tw_en;
    head_wa = tw_g;
    head_wd = '{free: tw_free, size: tw_sz};
    tail_we = tw_en;
    tail_wa = GW'(SW'(tw_g) + tw_sz - SW'(1));
    tail_wd = '{free: tw_free, size: tw_sz};
    if (ctl.op == ffa_pkg::OP_CLEAR) begin
      head_we = 1'b1;
      head_wa = clr_idx;
      head_wd = (clr_idx == '0) ? '{free: 1'b1, size: ffa_pkg::NIL} : '0;
      tail_we = 1'b1;
      tail_wa = clr_idx;
      tail_wd = st.clear_last ? '{free: 1'b1, size: ffa_pkg::NIL} : '0;
      prev_we = 1'b1;
      prev_wa = clr_idx;
      prev_wd = ffa_pkg::NIL;
      next_we = 1'b1;
      next_wa = clr_idx;
      next_wd = ffa_pkg::NIL;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    rd_head <= head_mem[rd_addr];
    rd_prev <= prev_mem[rd_addr];
    rd_next <= next_mem[rd_addr];
    rd_tail <= tail_mem[g - GW'(1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      list_head <= '0;
      given     <= '0;
      returned  <= '0;
      clr_idx   <= '0;
    end else begin
      unique case (ctl.op)
        ffa_pkg::OP_CLEAR:  clr_idx <= clr_idx + GW'(1);
        ffa_pkg::OP_DECODE: if (in_cmd == ffa_pkg::CMD_ALLOC) started <= 1'b1;
        ffa_pkg::OP_A_S2:   if (p_lk[SW-1]) list_head <= SW'(nb);
        ffa_pkg::OP_A_S3:   given <= given + CW'({need, {GS{1'b0}}});
        ffa_pkg::OP_A_U1: begin
          if (ul_p[SW-1]) list_head <= ul_n;
          given <= given + CW'({sz, {GS{1'b0}}});
        end
        ffa_pkg::OP_F_NMERGE, ffa_pkg::OP_F_PMERGE: if (ul_p[SW-1]) list_head <= ul_n;
        ffa_pkg::OP_F_CHK:  returned <= returned + CW'({hs, {GS{1'b0}}});
        ffa_pkg::OP_F_PUSH2: list_head <= SW'(g);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      ffa_pkg::OP_LATCH: begin
        in_cmd  <= cmd;
        in_req  <= request_bytes;
        in_addr <= block_address;
      end
      ffa_pkg::OP_DECODE: begin
        need     <= need_c;
        cur      <= list_head;
        steps    <= '0;
        g        <= g_c;
        res_addr <= '0;
        mf       <= 1'b0;
        mb       <= 1'b0;
        if (in_cmd == ffa_pkg::CMD_FREE) stat <= ffa_pkg::STAT_IGNORED;
        else if (in_req == '0)           stat <= ffa_pkg::STAT_ZERO;
        else                             stat <= ffa_pkg::STAT_NOFIT;
      end
      ffa_pkg::OP_A_NEXT: begin
        cur   <= rd_next;
        steps <= steps + SW'(1);
      end
      ffa_pkg::OP_A_TAKE: begin
        sz   <= hs;
        p_lk <= san_prev;
        n_lk <= san_next;
      end
      ffa_pkg::OP_A_S3, ffa_pkg::OP_A_U1: begin
        res_addr <= heap_base + AW'({cur[GW-1:0], {GS{1'b0}}}) +
                    AW'(ffa_pkg::HEADER_BYTES);
        stat     <= ffa_pkg::STAT_DONE;
      end
      ffa_pkg::OP_F_CHK:    sz <= hs;
      ffa_pkg::OP_F_NMERGE: begin
        sz <= sum_sz;
        mf <= 1'b1;
      end
      ffa_pkg::OP_F_PREAD1: pg <= pg_c;
      ffa_pkg::OP_F_PMERGE: begin
        sz <= sum_sz;
        g  <= pg;
        mb <= 1'b1;
      end
      ffa_pkg::OP_F_PUSH2:  stat <= ffa_pkg::STAT_DONE;
      default: begin
      end
    endcase
    if (ctl.load_out) begin
      result_address  <= res_addr;
      status          <= stat;
      used_bytes      <= given - returned;
      allocated_bytes <= given;
      merged_forward  <= mf;
      merged_backward <= mb;
    end
  end

endmodule

// ===== hdl/ffa_ctrl.sv =====
`timescale 1ns / 1ps
module ffa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ffa_pkg::dp_stat_t  st,
  output ffa_pkg::dp_cmd_t   ctl
);

  ffa_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ffa_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffa_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out)  out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next   = state;
    ctl.op       = ffa_pkg::OP_NONE;
    ctl.load_out = 1'b0;
    unique case (state)
      ffa_pkg::ST_CLEAR: begin
        ctl.op = ffa_pkg::OP_CLEAR;
        if (st.clear_last) state_next = ffa_pkg::ST_IDLE;
      end
      ffa_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctl.op     = ffa_pkg::OP_LATCH;
          state_next = ffa_pkg::ST_DECODE;
        end
      end
      ffa_pkg::ST_DECODE: begin
        ctl.op = ffa_pkg::OP_DECODE;
        if (st.is_free) state_next = st.free_bad ? ffa_pkg::ST_DONE : ffa_pkg::ST_F_READ;
        else            state_next = st.req_zero ? ffa_pkg::ST_DONE : ffa_pkg::ST_A_READ;
      end
      ffa_pkg::ST_A_READ: begin
        if (st.walk_end) begin
          state_next = ffa_pkg::ST_DONE;
        end else begin
          ctl.op     = ffa_pkg::OP_A_READ;
          state_next = ffa_pkg::ST_A_EVAL;
        end
      end
      ffa_pkg::ST_A_EVAL: begin
        if (st.fit) begin
          ctl.op     = ffa_pkg::OP_A_TAKE;
          state_next = st.split ? ffa_pkg::ST_A_S1 : ffa_pkg::ST_A_U1;
        end else begin
          ctl.op     = ffa_pkg::OP_A_NEXT;
          state_next = ffa_pkg::ST_A_READ;
        end
      end
      ffa_pkg::ST_A_S1: begin
        ctl.op     = ffa_pkg::OP_A_S1;
        state_next = ffa_pkg::ST_A_S2;
      end
      ffa_pkg::ST_A_S2: begin
        ctl.op     = ffa_pkg::OP_A_S2;
        state_next = ffa_pkg::ST_A_S3;
      end
      ffa_pkg::ST_A_S3: begin
        ctl.op     = ffa_pkg::OP_A_S3;
        state_next = ffa_pkg::ST_DONE;
      end
      ffa_pkg::ST_A_U1: begin
        ctl.op     = ffa_pkg::OP_A_U1;
        state_next = ffa_pkg::ST_DONE;
      end
      ffa_pkg::ST_F_READ: begin
        ctl.op     = ffa_pkg::OP_F_READ;
        state_next = ffa_pkg::ST_F_CHK;
      end
      ffa_pkg::ST_F_CHK: begin
        if (st.free_ok) begin
          ctl.op     = ffa_pkg::OP_F_CHK;
          state_next = ffa_pkg::ST_F_NREAD;
        end else begin
          state_next = ffa_pkg::ST_DONE;
        end
      end
      ffa_pkg::ST_F_NREAD: begin
        if (st.nx_valid) begin
          ctl.op     = ffa_pkg::OP_F_NREAD;
          state_next = ffa_pkg::ST_F_NCHK;
        end else begin
          state_next = ffa_pkg::ST_F_PREAD;
        end
      end
      ffa_pkg::ST_F_NCHK: begin
        if (st.nmerge) ctl.op = ffa_pkg::OP_F_NMERGE;
        state_next = ffa_pkg::ST_F_PREAD;
      end
      ffa_pkg::ST_F_PREAD: begin
        // The tail tag just below the block is read here.
        state_next = st.g_nonzero ? ffa_pkg::ST_F_PCHK0 : ffa_pkg::ST_F_PUSH1;
      end
      ffa_pkg::ST_F_PCHK0: begin
        if (st.prev_cand) begin
          ctl.op     = ffa_pkg::OP_F_PREAD1;
          state_next = ffa_pkg::ST_F_PCHK1;
        end else begin
          state_next = ffa_pkg::ST_F_PUSH1;
        end
      end
      ffa_pkg::ST_F_PCHK1: begin
        if (st.pmerge) ctl.op = ffa_pkg::OP_F_PMERGE;
        state_next = ffa_pkg::ST_F_PUSH1;
      end
      ffa_pkg::ST_F_PUSH1: begin
        ctl.op     = ffa_pkg::OP_F_PUSH1;
        state_next = ffa_pkg::ST_F_PUSH2;
      end
      ffa_pkg::ST_F_PUSH2: begin
        ctl.op     = ffa_pkg::OP_F_PUSH2;
        state_next = ffa_pkg::ST_DONE;
      end
      ffa_pkg::ST_DONE: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = ffa_pkg::ST_IDLE;
        end
      end
      default: state_next = ffa_pkg::ST_IDLE;
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ffa_pkg::ST_DECODE))
    else $error("accepted transaction did not reach decode");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ffa_pkg::ST_DONE && out_free) |=> (out_valid && state == ffa_pkg::ST_IDLE))
    else $error("finished transaction not presented");

  a_split_seq: assert property (@(posedge clk) disable iff (rst)
    (state == ffa_pkg::ST_A_S1) |=> (state == ffa_pkg::ST_A_S2) ##1 (state == ffa_pkg::ST_A_S3))
    else $error("split write sequence broken");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == ffa_pkg::ST_A_READ && st.walk_end) |=> (state == ffa_pkg::ST_DONE))
    else $error("walk did not stop at end of list");

endmodule

// ===== hdl/first_fit_heap_allocator_top.sv =====
`timescale 1ns / 1ps
// First-fit heap allocator with boundary tags over 65536 granules of 16 bytes.
// Input channel (in_valid/in_stall) carries one transaction: cmd (0 allocate,
// 1 free), request_bytes and block_address. Output channel (out_valid/out_stall)
// returns one result transaction per input: result_address, status, byte
// counters and merge flags. An item is taken when valid is high and stall low.
// One transaction is processed at a time. An allocate walks the free list,
// a registered memory read and an evaluate step per entry visited, then
// writes a fit through states A_S1, A_S2 and A_S3 when it splits a block or
// A_U1 when it takes a whole one; a walk that finds none ends in the result.
// A zero-size allocate goes from decode straight to the result. A free runs
// the tag check, the neighbor merges and the list push; a rejected free goes
// from decode to the result, or ends at the tag check when its head tag is
// bad. The next transaction is taken in the cycle after the result is loaded.
// A finished result sits in an output register, so a new transaction is taken
// while the previous result is still stalled; the engine then waits in its
// last state until the output register is free.
// After reset the block clears all 65536 entries of its tag and link memories
// with in_stall high. heap_base is written over APB at address 0; the user must
// write it only while the engine is idle, as the block does not enforce this.
module first_fit_heap_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [ffa_pkg::REQ_W-1:0]       request_bytes,
  input  logic [ffa_pkg::ADDR_W-1:0]      block_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ffa_pkg::ADDR_W-1:0]      result_address,
  output logic [1:0]                      status,
  output logic [ffa_pkg::CNT_W-1:0]       used_bytes,
  output logic [ffa_pkg::CNT_W-1:0]       allocated_bytes,
  output logic                            merged_forward,
  output logic                            merged_backward,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffa_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [ffa_pkg::ADDR_W-1:0] heap_base;
  logic                       base_sel;
  ffa_pkg::dp_cmd_t           ctl;
  ffa_pkg::dp_stat_t          st;

  assign pready   = 1'b1;
  assign base_sel = (paddr[ffa_pkg::PADDR_W-1:2] == '0);
  assign prdata   = base_sel ? heap_base : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (psel && penable && pwrite && pready && base_sel) begin
      heap_base <= pwdata;
    end
  end

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .ctl       (ctl)
  );

  ffa_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .st              (st),
    .heap_base       (heap_base),
    .cmd             (cmd),
    .request_bytes   (request_bytes),
    .block_address   (block_address),
    .result_address  (result_address),
    .status          (status),
    .used_bytes      (used_bytes),
    .allocated_bytes (allocated_bytes),
    .merged_forward  (merged_forward),
    .merged_backward (merged_backward)
  );

endmodule

// ===== verif/ffa_checker.sv =====
`timescale 1ns / 1ps
module ffa_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         cmd,
  input  logic [ffa_pkg::REQ_W-1:0]    request_bytes,
  input  logic [ffa_pkg::ADDR_W-1:0]   block_address,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [ffa_pkg::ADDR_W-1:0]   result_address,
  input  logic [1:0]                   status,
  input  logic [ffa_pkg::CNT_W-1:0]    used_bytes,
  input  logic [ffa_pkg::CNT_W-1:0]    allocated_bytes,
  input  logic                         merged_forward,
  input  logic                         merged_backward,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [ffa_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output int                           errors,
  output int                           pending
);

  localparam int AW = ffa_pkg::ADDR_W;
  localparam int CW = ffa_pkg::CNT_W;
  localparam int SW = ffa_pkg::SIZE_W;
  localparam int GN = ffa_pkg::GRANULES;
  localparam logic [SW-1:0] NIL = ffa_pkg::NIL;
  localparam logic [ffa_pkg::PADDR_W-1:0] REG_HEAP_BASE = '0;
  localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [AW-1:0]   addr;
    ffa_pkg::stat_t  stat;
    logic [CW-1:0]   used;
    logic [CW-1:0]   given;
    logic            fwd;
    logic            bwd;
  } heap_result_t;

  logic [SW-1:0]     hsize [GN];
  logic              hfree [GN];
  logic [SW-1:0]     tsize [GN];
  logic              tfree [GN];
  logic [SW-1:0]     lprev [GN];
  logic [SW-1:0]     lnext [GN];
  logic [SW-1:0]     list_top;
  logic [AW-1:0]     base;
  longint unsigned   given_bytes, returned_bytes;
  bit                started, model_ready;
  heap_result_t      expected_results[$];

  function automatic bit span_ok(longint unsigned g, longint unsigned sz);
    return sz != 0 && g + sz <= GN;
  endfunction

  function automatic void tag_write(int unsigned g, int unsigned sz, logic fr);
    hsize[g] = sz;
    hfree[g] = fr;
    tsize[g + sz - 1] = sz;
    tfree[g + sz - 1] = fr;
  endfunction

  function automatic void unlink(int unsigned g);
    logic [SW-1:0] p, n;
    p = lprev[g];
    n = lnext[g];
    if (p >= GN) p = NIL;
    if (n >= GN) n = NIL;
    if (p != NIL) lnext[p] = n;
    else list_top = n;
    if (n != NIL) lprev[n] = p;
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < GN; i++) begin
      hsize[i] = '0; hfree[i] = 0; tsize[i] = '0; tfree[i] = 0;
      lprev[i] = NIL; lnext[i] = NIL;
    end
    tag_write(0, GN, 1);
    list_top = '0;
    base = '0;
    given_bytes = 0;
    returned_bytes = 0;
    started = 0;
  endfunction

  function automatic void alloc_block(longint unsigned req, ref heap_result_t r);
    longint unsigned total, need, sz, bsize;
    int unsigned cur, nb;
    logic [SW-1:0] p, n;
    total = (req + ffa_pkg::HEADER_BYTES + ffa_pkg::FOOTER_BYTES + 15) & ~64'd15;
    need = total / 16;
    started = 1;
    if (req == 0) begin
      r.stat = ffa_pkg::STAT_ZERO;
      return;
    end
    cur = list_top;
    for (int steps = 0; steps < GN && cur < GN; steps++) begin
      sz = hsize[cur];
      if (hfree[cur] && span_ok(cur, sz) && sz >= need) begin
        if (sz * 16 > total + ffa_pkg::HEADER_BYTES + ffa_pkg::FOOTER_BYTES +
                      ffa_pkg::SPLIT_SLACK) begin
          // The remainder keeps the list position of the block it came from.
          nb = cur + need;
          p = lprev[cur];
          n = lnext[cur];
          if (p >= GN) p = NIL;
          if (n >= GN) n = NIL;
          tag_write(nb, sz - need, 1);
          lprev[nb] = p;
          lnext[nb] = n;
          if (n != NIL) lprev[n] = nb;
          if (p != NIL) lnext[p] = nb;
          else list_top = nb;
          tag_write(cur, need, 0);
          lprev[cur] = NIL;
          lnext[cur] = NIL;
          bsize = need;
        end else begin
          unlink(cur);
          tag_write(cur, sz, 0);
          bsize = sz;
        end
        given_bytes = (given_bytes + bsize * 16) & MASK48;
        r.addr = AW'(longint'(base) + longint'(cur) * 16 + ffa_pkg::HEADER_BYTES);
        r.stat = ffa_pkg::STAT_DONE;
        return;
      end
      cur = lnext[cur];
    end
    r.stat = ffa_pkg::STAT_NOFIT;
  endfunction

  function automatic void free_block(logic [AW-1:0] a, ref heap_result_t r);
    longint unsigned lo, off, nsz, ps, hs;
    int unsigned g, sz, nx, pg;
    r.stat = ffa_pkg::STAT_IGNORED;
    lo = longint'(base) + ffa_pkg::HEADER_BYTES;
    if (a == 0 || !started || longint'(a) < lo) return;
    off = longint'(a) - lo;
    if (off >= longint'(GN) * 16 || off % 16 != 0) return;
    g = off / 16;
    sz = hsize[g];
    if (!span_ok(g, sz)) return;
    tag_write(g, sz, 1);
    returned_bytes = (returned_bytes + longint'(sz) * 16) & MASK48;
    nx = g + sz;
    if (nx < GN) begin
      nsz = hsize[nx];
      if (hfree[nx] && nsz != 0 && span_ok(g, sz + nsz)) begin
        unlink(nx);
        sz += nsz;
        tag_write(g, sz, 1);
        r.fwd = 1;
      end
    end
    if (g > 0) begin
      ps = tsize[g - 1];
      if (ps != 0 && ps <= g) begin
        pg = g - ps;
        hs = hsize[pg];
        if (hfree[pg] && hs != 0 && span_ok(pg, hs + sz)) begin
          unlink(pg);
          sz += hs;
          tag_write(pg, sz, 1);
          g = pg;
          r.bwd = 1;
        end
      end
    end
    if (list_top >= GN) list_top = NIL;
    lnext[g] = list_top;
    lprev[g] = NIL;
    if (list_top != NIL) lprev[list_top] = g;
    list_top = g;
    r.stat = ffa_pkg::STAT_DONE;
  endfunction

  always @(posedge clk) begin
    heap_result_t r, e;
    int nerr;
    nerr = 0;
    if (rst) begin
      if (!model_ready) begin
        heap_reset();
        model_ready = 1;
      end
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_HEAP_BASE)
        base = pwdata;
      if (in_valid && !in_stall) begin
        r = '{addr: '0, stat: ffa_pkg::STAT_DONE, used: '0, given: '0, fwd: 0, bwd: 0};
        if (cmd == ffa_pkg::CMD_ALLOC) alloc_block(request_bytes, r);
        else free_block(block_address, r);
        r.used = CW'(given_bytes - returned_bytes);
        r.given = CW'(given_bytes);
        expected_results.push_back(r);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          nerr++;
        end else begin
          e = expected_results.pop_front();
          if (result_address !== e.addr) begin
            $error("result_address expected %h got %h", e.addr, result_address);
            nerr++;
          end
          if (status !== e.stat) begin
            $error("status expected %0d got %0d", e.stat, status);
            nerr++;
          end
          if (used_bytes !== e.used) begin
            $error("used_bytes expected %h got %h", e.used, used_bytes);
            nerr++;
          end
          if (allocated_bytes !== e.given) begin
            $error("allocated_bytes expected %h got %h", e.given, allocated_bytes);
            nerr++;
          end
          if (merged_forward !== e.fwd) begin
            $error("merged_forward expected %0d got %0d", e.fwd, merged_forward);
            nerr++;
          end
          if (merged_backward !== e.bwd) begin
            $error("merged_backward expected %0d got %0d", e.bwd, merged_backward);
            nerr++;
          end
        end
      end
      errors <= errors + nerr;
    end
    pending = expected_results.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int PHASE_ITEMS = 480;
  localparam logic [ffa_pkg::PADDR_W-1:0] REG_HEAP_BASE = '0;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_stall, cmd = ffa_pkg::CMD_ALLOC;
  logic [ffa_pkg::REQ_W-1:0] request_bytes = '0;
  logic [ffa_pkg::ADDR_W-1:0] block_address = '0;
  logic out_valid, out_stall = 0;
  logic [ffa_pkg::ADDR_W-1:0] result_address;
  logic [1:0] status;
  logic [ffa_pkg::CNT_W-1:0] used_bytes, allocated_bytes;
  logic merged_forward, merged_backward;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [ffa_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int errors, pending;
  int cycles = 0, items = 0, allocs = 0, frees = 0;
  bit quiet = 0;
  logic [ffa_pkg::ADDR_W-1:0] live_ptrs[$];
  logic [ffa_pkg::ADDR_W-1:0] last_freed, a0, a1, a2;
  logic [ffa_pkg::ADDR_W-1:0] phase_base[4] = '{32'h0, 32'hFFFF_FFF0, 32'h0, 32'h1000_0000};

  always #5 clk = ~clk;

  first_fit_heap_allocator_top i_dut (.*);

  ffa_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Successful allocations become candidates for later frees.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall && status == ffa_pkg::STAT_DONE &&
        result_address != 0)
      live_ptrs.push_back(result_address);

  always @(negedge clk)
    out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 17);

  task automatic send(logic c, logic [ffa_pkg::REQ_W-1:0] r,
                      logic [ffa_pkg::ADDR_W-1:0] a);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 17) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    cmd = c;
    request_bytes = r;
    block_address = a;
    do @(posedge clk); while (in_stall);
    items++;
    if (c == ffa_pkg::CMD_ALLOC) allocs++;
    else frees++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_write(logic [ffa_pkg::PADDR_W-1:0] a, logic [31:0] d);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = a; pwdata = d;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic random_item();
    int k, pick;
    logic [ffa_pkg::REQ_W-1:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 55 || live_ptrs.size() == 0) begin
      k = $urandom_range(0, 99);
      if (k < 85) r = $urandom_range(1, 512);
      else if (k < 93) r = $urandom_range(1, 8192);
      else if (k < 96) r = 0;
      else r = $urandom_range(0, 1048576);
      send(ffa_pkg::CMD_ALLOC, r, $urandom);
    end else if (pick < 93) begin
      k = $urandom_range(0, live_ptrs.size() - 1);
      last_freed = live_ptrs[k];
      live_ptrs.delete(k);
      send(ffa_pkg::CMD_FREE, $urandom_range(0, 1048576), last_freed);
    end else if (pick < 97) begin
      send(ffa_pkg::CMD_FREE, $urandom_range(0, 1048576), $urandom);
    end else begin
      k = $urandom_range(0, live_ptrs.size() - 1);
      send(ffa_pkg::CMD_FREE, '0, live_ptrs[k] + $urandom_range(1, 64));
    end
  endtask

  initial begin
    phase_base[2] = $urandom & ~32'hF;
    repeat (10) @(posedge clk);
    rst = 0;
    // The engine clears its memories first and holds off input meanwhile.
    @(negedge clk);
    while (in_stall) @(negedge clk);
    apb_write(REG_HEAP_BASE, phase_base[0]);

    send(ffa_pkg::CMD_FREE, 0, 32'd32);
    send(ffa_pkg::CMD_ALLOC, 0, $urandom);
    send(ffa_pkg::CMD_FREE, 0, 32'd0);
    send(ffa_pkg::CMD_ALLOC, 21'd1048576, 0);
    send(ffa_pkg::CMD_ALLOC, 21'd1, 0);
    send(ffa_pkg::CMD_ALLOC, 21'd100, 0);
    send(ffa_pkg::CMD_ALLOC, 21'd200, 0);
    send(ffa_pkg::CMD_ALLOC, 21'd1048575, 0);
    drain();
    a0 = live_ptrs[0]; a1 = live_ptrs[1]; a2 = live_ptrs[2];
    live_ptrs.delete();
    send(ffa_pkg::CMD_FREE, 0, a0 + 8);
    send(ffa_pkg::CMD_FREE, 0, a0 + 16);
    send(ffa_pkg::CMD_FREE, 0, 32'd16);
    send(ffa_pkg::CMD_FREE, 0, 32'd32 + 32'd1048576);
    send(ffa_pkg::CMD_FREE, 21'h1FFFFF, 32'hFFFF_FFFF);
    send(ffa_pkg::CMD_FREE, 0, a1);
    send(ffa_pkg::CMD_FREE, 0, a0);
    send(ffa_pkg::CMD_FREE, 0, a2);
    send(ffa_pkg::CMD_ALLOC, 21'd100, 0);
    send(ffa_pkg::CMD_ALLOC, 21'd2000, 0);
    send(ffa_pkg::CMD_ALLOC, 21'd32, 0);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        drain();
        apb_write(REG_HEAP_BASE, phase_base[ph]);
        live_ptrs.delete();
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        quiet = (items >= 700 && items < 1000);
        random_item();
      end
    end
    quiet = 0;

    // A second free of the same block is accepted by design.
    drain();
    if (live_ptrs.size() != 0) begin
      last_freed = live_ptrs.pop_back();
      send(ffa_pkg::CMD_FREE, 0, last_freed);
    end
    send(ffa_pkg::CMD_FREE, 0, last_freed);
    send(ffa_pkg::CMD_ALLOC, 21'd64, 0);
    drain();
    repeat (40) @(posedge clk);

    $display("Covered %0d transactions: %0d allocates, %0d frees, four heap bases.",
             items, allocs, frees);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== first_fit_heap_allocator_top.f =====
hdl/ffa_pkg.sv
hdl/ffa_dp.sv
hdl/ffa_ctrl.sv
hdl/first_fit_heap_allocator_top.sv
verif/ffa_checker.sv
verif/tb.sv
